// ----- rtl/npcs_pkg.sv -----
package npcs_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int CHAN_W = 8;
  localparam int QUERY_W = 10;
  localparam int SQ_W = 2 * CHAN_W;
  localparam int DIST_W = 18;
  localparam int WORD_W = 3 * CHAN_W;
  localparam logic [CHAN_W-1:0] CHANNEL_MAX = 8'd255;
  localparam logic [7:0] THRESHOLD_RESET = 8'd8;
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } colour_t;

  // one squared-difference triple on its way to the compare stage
  typedef struct packed {
    logic valid;
    logic last;
    logic [IDX_W-1:0] index;
    logic [SQ_W-1:0] sq_red;
    logic [SQ_W-1:0] sq_green;
    logic [SQ_W-1:0] sq_blue;
  } dist_t;

  function automatic logic [CHAN_W-1:0] sat_channel(input logic [QUERY_W-1:0] v);
    logic [CHAN_W-1:0] r;
    if (v > QUERY_W'(CHANNEL_MAX)) begin
      r = CHANNEL_MAX;
    end else begin
      r = v[CHAN_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/nearest_palette_colour_search.sv -----
// Palette nearest-colour search. A request with mode 0 writes one palette entry;
// busy stays low. A request with mode 1 saturates the query colour and scans the
// palette memory from index 0, one read per cycle, comparing squared distances.
// The scan ends on the first improving entry whose distance is below the
// threshold register (config_write/config_data, reset value 8), or after the
// last entry. The single read port of the palette memory sets the sweep; each
// read then passes the memory read and the squaring stage. The result shows on
// the result ports for one cycle with result_valid high, in the first cycle that
// busy is low again; it cannot be held off, so the receiver must take it then.
module nearest_palette_colour_search (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        mode,
  input  logic [7:0]  entry_index,
  input  logic [7:0]  entry_red,
  input  logic [7:0]  entry_green,
  input  logic [7:0]  entry_blue,
  input  logic [9:0]  query_red,
  input  logic [9:0]  query_green,
  input  logic [9:0]  query_blue,
  input  logic        config_write,
  input  logic [7:0]  config_data,
  output logic        result_valid,
  output logic [7:0]  nearest_index,
  output logic [17:0] best_distance,
  output logic        stopped_early
);
  import npcs_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t state, state_next;
  logic [7:0] threshold;
  colour_t query;
  logic [IDX_W-1:0] issue_idx;
  logic issuing;
  logic rd_valid, rd_last;
  logic [IDX_W-1:0] rd_index;
  logic [DIST_W-1:0] best;
  logic [IDX_W-1:0] found;
  logic have_best;

  colour_t wdata, rdata;
  dist_t sqd;
  logic accept, load_we, rd_en, issue_last;
  logic [DIST_W-1:0] sum;
  logic take, hit, finish;

  assign accept = start && !busy;
  assign busy = (state != ST_IDLE);
  assign load_we = accept && (mode == MODE_LOAD) && (32'(entry_index) < PALETTE_ENTRIES);
  assign wdata = '{red: entry_red, green: entry_green, blue: entry_blue};
  assign rd_en = (state == ST_SCAN) && issuing;
  assign issue_last = (issue_idx == IDX_W'(PALETTE_ENTRIES - 1));

  npcs_palette_ram u_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (IDX_W'(entry_index)),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (issue_idx),
    .rdata (rdata)
  );

  npcs_distance u_dist (
    .clk      (clk),
    .rst      (rst),
    .flush    (finish),
    .in_valid (rd_valid),
    .in_last  (rd_last),
    .in_index (rd_index),
    .entry    (rdata),
    .query    (query),
    .sqd      (sqd)
  );

  assign sum = DIST_W'(sqd.sq_red) + DIST_W'(sqd.sq_green) + DIST_W'(sqd.sq_blue);
  // the first entry always wins against the open start distance
  assign take = sqd.valid && (!have_best || (sum < best));
  assign hit = take && (sum < DIST_W'(threshold));
  assign finish = sqd.valid && (hit || sqd.last);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (mode == MODE_QUERY)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (finish) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      threshold <= THRESHOLD_RESET;
      issuing <= 1'b0;
      rd_valid <= 1'b0;
      have_best <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (config_write) begin
        threshold <= config_data;
      end
      result_valid <= finish;
      rd_valid <= rd_en && !finish;
      if (accept && (mode == MODE_QUERY)) begin
        issuing <= 1'b1;
        have_best <= 1'b0;
      end else begin
        if (finish || (rd_en && issue_last)) begin
          issuing <= 1'b0;
        end
        if (take) begin
          have_best <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (mode == MODE_QUERY)) begin
      query <= '{red: sat_channel(query_red), green: sat_channel(query_green),
                 blue: sat_channel(query_blue)};
      issue_idx <= '0;
    end else if (rd_en && !issue_last) begin
      issue_idx <= issue_idx + IDX_W'(1);
    end
    rd_last <= issue_last;
    rd_index <= issue_idx;
    if (take) begin
      best <= sum;
      found <= sqd.index;
    end
    if (finish) begin
      nearest_index <= take ? 8'(sqd.index) : 8'(found);
      best_distance <= take ? sum : best;
      stopped_early <= hit;
    end
  end

  // no read may be in flight outside a scan
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!rd_valid && !sqd.valid && !issuing))
    else $error("palette read in flight while idle");

  // early stop only on a distance under the threshold
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && stopped_early) |-> (best_distance < DIST_W'(threshold)))
    else $error("early stop above threshold");

  // a result always closes a scan
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ($past(state) == ST_SCAN) && (state == ST_IDLE))
    else $error("result without a scan");

  assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe longer than one cycle");

endmodule

// ----- rtl/npcs_palette_ram.sv -----
module npcs_palette_ram (
  input  logic                      clk,
  input  logic                      we,
  input  logic [npcs_pkg::IDX_W-1:0] waddr,
  input  npcs_pkg::colour_t         wdata,
  input  logic                      re,
  input  logic [npcs_pkg::IDX_W-1:0] raddr,
  output npcs_pkg::colour_t         rdata
);
  import npcs_pkg::*;

  colour_t mem [PALETTE_ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/npcs_distance.sv -----
module npcs_distance (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       flush,
  input  logic                       in_valid,
  input  logic                       in_last,
  input  logic [npcs_pkg::IDX_W-1:0] in_index,
  input  npcs_pkg::colour_t          entry,
  input  npcs_pkg::colour_t          query,
  output npcs_pkg::dist_t            sqd
);
  import npcs_pkg::*;

  function automatic logic [SQ_W-1:0] sq_diff(input logic [CHAN_W-1:0] a,
                                              input logic [CHAN_W-1:0] b);
    logic [CHAN_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      sqd.valid <= 1'b0;
    end else begin
      sqd.valid <= in_valid;
    end
    sqd.last     <= in_last;
    sqd.index    <= in_index;
    sqd.sq_red   <= sq_diff(entry.red, query.red);
    sqd.sq_green <= sq_diff(entry.green, query.green);
    sqd.sq_blue  <= sq_diff(entry.blue, query.blue);
  end

endmodule
